// ----- rtl/wpp_pkg.sv -----
// shared types, codes and tables for the wav pcm stream parser
// used by every module of the block; depends on nothing
`default_nettype none

package wpp_pkg;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  // case-folded chunk tags, first byte in the low bits
  localparam logic [31:0] TAG_RIFF = 32'h6666_6972;
  localparam logic [31:0] TAG_WAVE = 32'h6576_6177;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [31:0] AFMT_PCM     = 32'd1;
  localparam logic [15:0] DEPTH_8      = 16'd8;
  localparam logic [15:0] DEPTH_16     = 16'd16;
  localparam logic [15:0] DEPTH_32     = 16'd32;
  localparam logic [31:0] OFFSET_8     = 32'd128;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_RIFF = 3'd1;
  localparam logic [2:0] ERR_FMT  = 3'd2;
  localparam logic [2:0] ERR_AFMT = 3'd3;
  localparam logic [2:0] ERR_DATA = 3'd4;
  localparam logic [2:0] ERR_BITS = 3'd5;

  typedef enum logic [3:0] {
    PH_RIFF  = 4'd0,
    PH_RSIZE = 4'd1,
    PH_WAVE  = 4'd2,
    PH_FMT   = 4'd3,
    PH_FSIZE = 4'd4,
    PH_AFMT  = 4'd5,
    PH_CHAN  = 4'd6,
    PH_RATE  = 4'd7,
    PH_BRATE = 4'd8,
    PH_ALIGN = 4'd9,
    PH_BITS  = 4'd10,
    PH_DATA  = 4'd11,
    PH_DSIZE = 4'd12,
    PH_SAMP  = 4'd13,
    PH_IDLE  = 4'd14
  } phase_e;

  typedef enum logic [1:0] {
    EV_SAMPLE = 2'd0,
    EV_FORMAT = 2'd1,
    EV_ERROR  = 2'd2
  } ev_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [31:0] sample;
    logic [15:0]        channel;
    logic               last_sample;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [15:0]        bit_depth;
    logic [2:0]         error_code;
  } res_t;

  // decoded command handed from front to back
  typedef struct packed {
    ev_e         kind;
    logic [31:0] val;    // raw sample or sample rate
    logic [15:0] aux;    // channel index or channel count
    logic [15:0] depth;  // bit depth for the format beat
    logic [1:0]  blast;  // index of the last byte of the sample
    logic        last;
    logic [2:0]  err;
  } cmd_t;

  // index of the last byte of each header field
  function automatic logic [1:0] field_last(phase_e ph);
    logic [1:0] r;
    case (ph)
      PH_AFMT, PH_CHAN, PH_ALIGN, PH_BITS: r = 2'd1;
      default:                             r = 2'd3;
    endcase
    return r;
  endfunction

  // index of the last byte of one sample
  function automatic logic [1:0] sample_last(logic [15:0] bits);
    logic [1:0] r;
    if (bits == DEPTH_8) begin
      r = 2'd0;
    end else if (bits == DEPTH_16) begin
      r = 2'd1;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wav_pcm_stream_parser.sv -----
// top level of the wav pcm stream parser: front, command queue, back
// depends on wpp_pkg, wpp_front, wpp_queue and wpp_back
//
//   channel   dir  handshake                  beat
//   in_i      in   push_i / full_o            one file byte plus restart flag
//   res_o     out  empty_o / pop_i            sample, format info or error
//
// one byte is taken per cycle while full_o is low; full_o rises only when
// the two-entry command queue is full, i.e. when results back up behind a
// stalled pop_i; a result passes through the command queue and then the
// output register before it shows on res_o, when nothing waits ahead of it
// header bytes and leading sample bytes make no result but are held off too
// while full_o is high
// reset leaves the parser waiting for the riff tag with nothing queued
`default_nettype none

module wav_pcm_stream_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire wpp_pkg::in_t in_i,
  input  wire logic         push_i,
  output logic              full_o,
  output wpp_pkg::res_t     res_o,
  output logic              empty_o,
  input  wire logic         pop_i
);

  logic          acc;
  logic          cmd_vld;
  wpp_pkg::cmd_t cmd_f, cmd_b;
  logic          q_empty, q_pop;

  assign acc = push_i && !full_o;

  wpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .acc_i     (acc),
    .cmd_o     (cmd_f),
    .cmd_vld_o (cmd_vld)
  );

  wpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc && cmd_vld),
    .wdata_i (cmd_f),
    .full_o  (full_o),
    .pop_i   (q_pop),
    .rdata_o (cmd_b),
    .empty_o (q_empty)
  );

  wpp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_b),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .res_o     (res_o),
    .empty_o   (empty_o),
    .pop_i     (pop_i)
  );

endmodule

`default_nettype wire

// ----- rtl/wpp_front.sv -----
// front end: byte-serial header walk, field assembly and sample framing
// depends on wpp_pkg; emits at most one command per accepted byte
`default_nettype none

module wpp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wpp_pkg::in_t  in_i,
  input  wire logic          acc_i,
  output wpp_pkg::cmd_t      cmd_o,
  output logic               cmd_vld_o
);

  wpp_pkg::phase_e phase_q, phase_d, ph;
  logic [1:0]  idx_q, idx_d, idx;
  logic [31:0] shift_q, shift_d, sh, sh_n;
  logic [15:0] chan_q, chan_d, chan;
  logic [31:0] rate_q, rate_d, rate;
  logic [15:0] bits_q, bits_d, bits;
  logic [31:0] left_q, left_d, left;
  logic [15:0] cidx_q, cidx_d, cidx;
  logic [2:0]  perr_q, perr_d, perr;
  logic [7:0]  b;
  logic [1:0]  li;
  logic [31:0] v;
  logic [16:0] cidx_inc;

  always_comb begin
    // a start beat sees the reset state
    ph   = in_i.start_req ? wpp_pkg::PH_RIFF : phase_q;
    idx  = in_i.start_req ? 2'd0  : idx_q;
    sh   = in_i.start_req ? '0    : shift_q;
    chan = in_i.start_req ? '0    : chan_q;
    rate = in_i.start_req ? '0    : rate_q;
    bits = in_i.start_req ? '0    : bits_q;
    left = in_i.start_req ? '0    : left_q;
    cidx = in_i.start_req ? '0    : cidx_q;
    perr = in_i.start_req ? wpp_pkg::ERR_NONE : perr_q;

    b = in_i.byte_in;
    if ((ph inside {wpp_pkg::PH_RIFF, wpp_pkg::PH_WAVE, wpp_pkg::PH_FMT, wpp_pkg::PH_DATA})
        && (b inside {[8'h41:8'h5A]})) begin
      b = b + 8'h20;
    end
    sh_n = {b, sh[31:8]};
    li   = (ph == wpp_pkg::PH_SAMP) ? wpp_pkg::sample_last(bits) : wpp_pkg::field_last(ph);
    case (li)
      2'd0:    v = {24'd0, sh_n[31:24]};
      2'd1:    v = {16'd0, sh_n[31:16]};
      default: v = sh_n;
    endcase
    cidx_inc = {1'b0, cidx} + 17'd1;

    phase_d   = ph;
    idx_d     = idx;
    shift_d   = sh;
    chan_d    = chan;
    rate_d    = rate;
    bits_d    = bits;
    left_d    = left;
    cidx_d    = cidx;
    perr_d    = perr;
    cmd_vld_o = 1'b0;
    cmd_o     = '0;

    if (ph != wpp_pkg::PH_IDLE) begin
      shift_d = sh_n;
      if (idx < li) begin
        idx_d = idx + 2'd1;
      end else begin
        idx_d   = 2'd0;
        phase_d = wpp_pkg::phase_e'(4'(ph) + 4'd1);
        case (ph)
          wpp_pkg::PH_RIFF: begin
            if (v != wpp_pkg::TAG_RIFF) perr_d = wpp_pkg::ERR_RIFF;
          end
          wpp_pkg::PH_WAVE: begin
            if (perr != wpp_pkg::ERR_NONE || v != wpp_pkg::TAG_WAVE) begin
              phase_d   = wpp_pkg::PH_IDLE;
              cmd_vld_o = 1'b1;
              cmd_o.kind = wpp_pkg::EV_ERROR;
              cmd_o.err  = wpp_pkg::ERR_RIFF;
            end
          end
          wpp_pkg::PH_FMT: begin
            if (v != wpp_pkg::TAG_FMT) perr_d = wpp_pkg::ERR_FMT;
          end
          wpp_pkg::PH_FSIZE: begin
            if (perr != wpp_pkg::ERR_NONE || v != wpp_pkg::FMT_SIZE_PCM) begin
              phase_d   = wpp_pkg::PH_IDLE;
              cmd_vld_o = 1'b1;
              cmd_o.kind = wpp_pkg::EV_ERROR;
              cmd_o.err  = wpp_pkg::ERR_FMT;
            end
          end
          wpp_pkg::PH_AFMT: begin
            if (v != wpp_pkg::AFMT_PCM) begin
              phase_d   = wpp_pkg::PH_IDLE;
              cmd_vld_o = 1'b1;
              cmd_o.kind = wpp_pkg::EV_ERROR;
              cmd_o.err  = wpp_pkg::ERR_AFMT;
            end
          end
          wpp_pkg::PH_CHAN: chan_d = v[15:0];
          wpp_pkg::PH_RATE: rate_d = v;
          wpp_pkg::PH_BITS: begin
            bits_d    = v[15:0];
            cmd_vld_o = 1'b1;
            if (!(v[15:0] == wpp_pkg::DEPTH_8 || v[15:0] == wpp_pkg::DEPTH_16
                  || v[15:0] == wpp_pkg::DEPTH_32) || chan == 16'd0) begin
              phase_d    = wpp_pkg::PH_IDLE;
              cmd_o.kind = wpp_pkg::EV_ERROR;
              cmd_o.err  = wpp_pkg::ERR_BITS;
            end else begin
              phase_d     = wpp_pkg::PH_DATA;
              cmd_o.kind  = wpp_pkg::EV_FORMAT;
              cmd_o.val   = rate;
              cmd_o.aux   = chan;
              cmd_o.depth = v[15:0];
            end
          end
          wpp_pkg::PH_DATA: begin
            if (v != wpp_pkg::TAG_DATA) perr_d = wpp_pkg::ERR_DATA;
          end
          wpp_pkg::PH_DSIZE: begin
            if (perr != wpp_pkg::ERR_NONE) begin
              phase_d   = wpp_pkg::PH_IDLE;
              cmd_vld_o = 1'b1;
              cmd_o.kind = wpp_pkg::EV_ERROR;
              cmd_o.err  = wpp_pkg::ERR_DATA;
            end else begin
              // bytes per sample is a power of two
              case (wpp_pkg::sample_last(bits))
                2'd0:    left_d = v;
                2'd1:    left_d = v >> 1;
                default: left_d = v >> 2;
              endcase
              cidx_d  = '0;
              phase_d = (left_d == 32'd0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_SAMP;
            end
          end
          wpp_pkg::PH_SAMP: begin
            cmd_vld_o   = 1'b1;
            cmd_o.kind  = wpp_pkg::EV_SAMPLE;
            cmd_o.val   = v;
            cmd_o.aux   = cidx;
            cmd_o.blast = li;
            cmd_o.last  = (left == 32'd1);
            left_d      = left - 32'd1;
            cidx_d      = (cidx_inc >= {1'b0, chan}) ? 16'd0 : cidx_inc[15:0];
            phase_d     = (left == 32'd1) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_SAMP;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wpp_pkg::PH_RIFF;
      idx_q   <= '0;
      shift_q <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      left_q  <= '0;
      cidx_q  <= '0;
      perr_q  <= wpp_pkg::ERR_NONE;
    end else if (acc_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      left_q  <= left_d;
      cidx_q  <= cidx_d;
      perr_q  <= perr_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpp_queue.sv -----
// short command queue between front and back
// depends on wpp_pkg for the command type and depth
`default_nettype none

module wpp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire wpp_pkg::cmd_t wdata_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output wpp_pkg::cmd_t      rdata_o,
  output logic               empty_o
);

  wpp_pkg::cmd_t             ent_q [wpp_pkg::QDepth];
  logic [wpp_pkg::QAw-1:0]   wptr_q, rptr_q;
  logic [wpp_pkg::QAw:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (wpp_pkg::QAw+1)'(wpp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = ent_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (wpp_pkg::QAw+1)'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - (wpp_pkg::QAw+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + wpp_pkg::QAw'(1);
      if (pop_i)  rptr_q <= rptr_q + wpp_pkg::QAw'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpp_back.sv -----
// back end: turns commands into result beats and holds the output register
// depends on wpp_pkg; pulls from the command queue
`default_nettype none

module wpp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire wpp_pkg::cmd_t cmd_i,
  input  wire logic          q_empty_i,
  output logic               q_pop_o,
  output wpp_pkg::res_t      res_o,
  output logic               empty_o,
  input  wire logic          pop_i
);

  logic          vld_q, vld_d;
  wpp_pkg::res_t res_q, res_d;

  assign q_pop_o = !q_empty_i && (!vld_q || pop_i);
  assign res_o   = res_q;
  assign empty_o = !vld_q;

  always_comb begin
    vld_d = vld_q;
    if (q_pop_o) begin
      vld_d = 1'b1;
    end else if (pop_i) begin
      vld_d = 1'b0;
    end
  end

  always_comb begin
    res_d = '0;
    res_d.event_res = cmd_i.kind;
    case (cmd_i.kind)
      wpp_pkg::EV_SAMPLE: begin
        case (cmd_i.blast)
          // 8-bit data is offset binary
          2'd0:    res_d.sample = $signed({24'd0, cmd_i.val[7:0]} - wpp_pkg::OFFSET_8);
          2'd1:    res_d.sample = $signed({{16{cmd_i.val[15]}}, cmd_i.val[15:0]});
          default: res_d.sample = $signed(cmd_i.val);
        endcase
        res_d.channel     = cmd_i.aux;
        res_d.last_sample = cmd_i.last;
      end
      wpp_pkg::EV_FORMAT: begin
        res_d.channel_count = cmd_i.aux;
        res_d.rate_hz       = cmd_i.val;
        res_d.bit_depth     = cmd_i.depth;
      end
      wpp_pkg::EV_ERROR: begin
        res_d.error_code = cmd_i.err;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wpp_checker.sv -----
// port-level checks for the wav pcm stream parser, bound to the top level
// depends on wpp_pkg for the result type and codes
`default_nettype none

module wpp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          full_o,
  input wire wpp_pkg::res_t res_o,
  input wire logic          empty_o,
  input wire logic          pop_i
);

  // a waiting beat holds until it is taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(res_o)))
    else $error("result changed while stalled");

  // the queue only fills behind a waiting output beat
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("input held off with no result waiting");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.event_res == wpp_pkg::EV_ERROR) |->
      (res_o.error_code != wpp_pkg::ERR_NONE && res_o.error_code <= wpp_pkg::ERR_BITS))
    else $error("error beat without a valid code");

  a_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.event_res == wpp_pkg::EV_FORMAT) |->
      (res_o.channel_count != 16'd0
       && (res_o.bit_depth == wpp_pkg::DEPTH_8 || res_o.bit_depth == wpp_pkg::DEPTH_16
           || res_o.bit_depth == wpp_pkg::DEPTH_32)))
    else $error("format beat with unsupported layout");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && res_o.last_sample) |-> (res_o.event_res == wpp_pkg::EV_SAMPLE))
    else $error("last flag on a non-sample beat");

endmodule

bind wav_pcm_stream_parser wpp_checker u_wpp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full_o  (full_o),
  .res_o   (res_o),
  .empty_o (empty_o),
  .pop_i   (pop_i)
);

`default_nettype wire
